@@ rtl/puq_pkg.sv @@
package puq_pkg;

  localparam int unsigned NUM_USERS = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVER     = 2'd1;
  localparam logic [1:0] ST_NEW_OVER = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [31:0] DEFAULT_QUOTA_RST = 32'd5000;

  typedef struct packed {
    logic        done;
    logic [31:0] user_id;
    logic [31:0] size_change;
    logic [1:0]  status;
    logic [31:0] used;
    logic [31:0] quota;
  } token_t;

  // signed change larger than the unsigned default quota
  function automatic logic over_default(input logic [31:0] sc, input logic [31:0] dq);
    over_default = $signed({sc[31], sc}) > $signed({1'b0, dq});
  endfunction

endpackage

@@ rtl/puq_ifs.sv @@
interface puq_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] user_id;
  logic [31:0] size_change;

  modport source (output valid, user_id, size_change, input ready);
  modport sink (input valid, user_id, size_change, output ready);
endinterface

interface puq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] used_after;
  logic [31:0] user_quota;

  modport source (output valid, status, used_after, user_quota, input ready);
  modport sink (input valid, status, used_after, user_quota, output ready);
endinterface

@@ rtl/puq_cell.sv @@
module puq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         default_quota,
  input  logic                tok_vld_i,
  input  puq_pkg::token_t     tok_i,
  output logic                tok_vld_o,
  output puq_pkg::token_t     tok_o
);

  logic            valid_r;
  logic [31:0]     user_r;
  logic [31:0]     used_r;
  logic [31:0]     limit_r;
  logic            tok_vld_r;
  puq_pkg::token_t tok_r;
  puq_pkg::token_t tok_nxt;

  logic        live;
  logic        hit;
  logic        fre;
  logic [33:0] sum;
  logic        over;
  logic [31:0] upd_used;
  logic [31:0] new_used;
  logic        new_over;

  assign live     = tok_vld_i && !tok_i.done;
  assign hit      = live && valid_r && (user_r == tok_i.user_id);
  assign fre      = live && !valid_r;
  assign sum      = {2'b00, used_r} + {{2{tok_i.size_change[31]}}, tok_i.size_change};
  assign over     = $signed(sum) > $signed({2'b00, limit_r});
  assign upd_used = sum[33] ? 32'd0 : sum[31:0];
  assign new_used = tok_i.size_change[31] ? 32'd0 : tok_i.size_change;
  assign new_over = puq_pkg::over_default(tok_i.size_change, default_quota);

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = over ? puq_pkg::ST_OVER : puq_pkg::ST_OK;
      tok_nxt.used   = over ? used_r : upd_used;
      tok_nxt.quota  = limit_r;
    end else if (fre) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = new_over ? puq_pkg::ST_NEW_OVER : puq_pkg::ST_OK;
      tok_nxt.used   = new_over ? 32'd0 : new_used;
      tok_nxt.quota  = default_quota;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
      if (fre && !new_over) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (hit && !over) begin
      used_r <= upd_used;
    end
    if (fre && !new_over) begin
      user_r  <= tok_i.user_id;
      used_r  <= new_used;
      limit_r <= default_quota;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;

endmodule

@@ rtl/per_user_quota_table.sv @@
// path from input beat to result beat: 16 cells, one final stage, output register
// one request at a time; the request walks the cell row one cell a cycle
// a new request is taken once the previous result has moved into the output register, even if it waits there
// reset: synchronous active low, clears all entry valid marks and sets default quota to 5000
module per_user_quota_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  puq_req_if.sink     in_ch,
  puq_res_if.source   out_ch
);

  logic            tok_vld [puq_pkg::NUM_USERS+1];
  puq_pkg::token_t tok     [puq_pkg::NUM_USERS+1];

  logic [31:0]     dq_r;
  logic            busy_r;
  logic            pend_vld_r;
  puq_pkg::token_t pend_r;
  puq_pkg::token_t fin;
  logic            out_vld_r;
  logic [1:0]      out_status_r;
  logic [31:0]     out_used_r;
  logic [31:0]     out_quota_r;
  logic            accept;
  logic            move;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign move        = pend_vld_r && (!out_vld_r || out_ch.ready);

  always_comb begin
    tok_vld[0]            = accept;
    tok[0].done           = 1'b0;
    tok[0].user_id        = in_ch.user_id;
    tok[0].size_change    = in_ch.size_change;
    tok[0].status         = puq_pkg::ST_OK;
    tok[0].used           = 32'd0;
    tok[0].quota          = 32'd0;
  end

  for (genvar i = 0; i < puq_pkg::NUM_USERS; i++) begin : g_cell
    puq_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .default_quota (dq_r),
      .tok_vld_i     (tok_vld[i]),
      .tok_i         (tok[i]),
      .tok_vld_o     (tok_vld[i+1]),
      .tok_o         (tok[i+1])
    );
  end

  // no hit and no free slot
  always_comb begin
    fin = tok[puq_pkg::NUM_USERS];
    if (!fin.done) begin
      fin.status = puq_pkg::over_default(fin.size_change, dq_r) ?
                   puq_pkg::ST_NEW_OVER : puq_pkg::ST_FULL;
      fin.used   = 32'd0;
      fin.quota  = dq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_r       <= puq_pkg::DEFAULT_QUOTA_RST;
      busy_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dq_r <= cfg_wr_data;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end
      if (tok_vld[puq_pkg::NUM_USERS]) begin
        pend_vld_r <= 1'b1;
      end else if (move) begin
        pend_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld[puq_pkg::NUM_USERS]) begin
      pend_r <= fin;
    end
    if (move) begin
      out_status_r <= pend_r.status;
      out_used_r   <= pend_r.used;
      out_quota_r  <= pend_r.quota;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.used_after = out_used_r;
  assign out_ch.user_quota = out_quota_r;

endmodule
